FILE: rtl/u2u8_pkg.sv
// Shared types, constants and the byte formatter for the UCS-2 to UTF-8 encoder.
// No dependencies; imported by every module of the block.
package u2u8_pkg;

    localparam int UNIT_W       = 16;
    localparam int LEN_CFG_W    = 4;
    localparam int QDEPTH       = 4;
    localparam int QPTR_W       = $clog2(QDEPTH);
    localparam int QCNT_W       = $clog2(QDEPTH + 1);

    localparam logic [LEN_CFG_W-1:0] NAME_LENGTH_RESET = 4'd10;
    localparam logic [UNIT_W-1:0]    REPLACEMENT_CHAR  = 16'hFFFD;
    localparam logic [4:0]           SURROGATE_TOP     = 5'b11011;

    localparam logic [7:0] LEAD_TWO   = 8'hC0;
    localparam logic [7:0] LEAD_THREE = 8'hE0;
    localparam logic [7:0] CONT_MARK  = 8'h80;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       start_name;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_char;
    } out_item_t;

    typedef enum logic [1:0] {
        LEN_ONE   = 2'd0,
        LEN_TWO   = 2'd1,
        LEN_THREE = 2'd2
    } enc_len_t;

    typedef struct packed {
        logic [UNIT_W-1:0] unit;
        enc_len_t          len;
    } unit_entry_t;

    // Front to queue
    typedef struct packed {
        logic        push;
        unit_entry_t entry;
    } q_wr_t;

    // Queue to back
    typedef struct packed {
        logic        avail;
        unit_entry_t entry;
    } q_rd_t;

    function automatic logic [1:0] last_idx(input enc_len_t len);
        logic [1:0] r;
        unique case (len)
            LEN_ONE:   r = 2'd0;
            LEN_TWO:   r = 2'd1;
            LEN_THREE: r = 2'd2;
            default:   r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] enc_byte(input logic [UNIT_W-1:0] unit,
                                            input enc_len_t len,
                                            input logic [1:0] idx);
        logic [7:0] r;
        r = CONT_MARK | {2'b00, unit[5:0]};
        unique case (len)
            LEN_ONE:
                r = unit[7:0];
            LEN_TWO:
                if (idx == 2'd0)
                    r = LEAD_TWO | {3'b000, unit[10:6]};
            LEN_THREE:
                if (idx == 2'd0)
                    r = LEAD_THREE | {4'b0000, unit[15:12]};
                else if (idx == 2'd1)
                    r = CONT_MARK | {2'b00, unit[11:6]};
            default:
                r = unit[7:0];
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/u2u8_front.sv
// Front end: byte pairing, name bookkeeping and code unit classification.
// Depends on u2u8_pkg.
module u2u8_front
    import u2u8_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  in_item_t             item,
    input  logic                 cfg_we,
    input  logic [LEN_CFG_W-1:0] cfg_data,
    output q_wr_t                wr
);

    logic [LEN_CFG_W-1:0] name_length_reg, name_length_next;
    logic [7:0]           held_low_reg, held_low_next;
    logic                 expect_high_reg, expect_high_next;
    logic [LEN_CFG_W-1:0] units_done_reg, units_done_next;
    logic                 name_ended_reg, name_ended_next;

    logic [7:0]           held_eff;
    logic                 expect_eff;
    logic [LEN_CFG_W-1:0] done_eff;
    logic                 ended_eff;
    logic [UNIT_W-1:0]    unit;
    logic                 live;

    always_comb
    begin
        // start marker clears the name before the byte is handled
        held_eff   = item.start_name ? 8'h00 : held_low_reg;
        expect_eff = item.start_name ? 1'b0 : expect_high_reg;
        done_eff   = item.start_name ? '0 : units_done_reg;
        ended_eff  = item.start_name ? 1'b0 : name_ended_reg;

        live = !ended_eff && (done_eff < name_length_reg);
        unit = {item.in_byte, held_eff};

        held_low_next    = held_low_reg;
        expect_high_next = expect_high_reg;
        units_done_next  = units_done_reg;
        name_ended_next  = name_ended_reg;
        wr.push          = 1'b0;
        wr.entry.unit    = unit;
        wr.entry.len     = LEN_THREE;

        if (unit[15:7] == '0)
            wr.entry.len = LEN_ONE;
        else if (unit[15:11] == '0)
            wr.entry.len = LEN_TWO;
        else if (unit[15:11] == SURROGATE_TOP)
            wr.entry.unit = REPLACEMENT_CHAR;

        if (accept)
        begin
            held_low_next    = held_eff;
            expect_high_next = expect_eff;
            units_done_next  = done_eff;
            name_ended_next  = ended_eff;
            if (live)
            begin
                if (!expect_eff)
                begin
                    held_low_next    = item.in_byte;
                    expect_high_next = 1'b1;
                end
                else
                begin
                    expect_high_next = 1'b0;
                    if (unit == '0)
                        name_ended_next = 1'b1;
                    else
                    begin
                        units_done_next = done_eff + 1'b1;
                        wr.push         = 1'b1;
                    end
                end
            end
        end

        name_length_next = cfg_we ? cfg_data : name_length_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            name_length_reg <= NAME_LENGTH_RESET;
            held_low_reg    <= '0;
            expect_high_reg <= 1'b0;
            units_done_reg  <= '0;
            name_ended_reg  <= 1'b0;
        end
        else
        begin
            name_length_reg <= name_length_next;
            held_low_reg    <= held_low_next;
            expect_high_reg <= expect_high_next;
            units_done_reg  <= units_done_next;
            name_ended_reg  <= name_ended_next;
        end
    end

    // a unit only leaves on the high byte of a pair
    a_push_on_high: assert property (@(posedge clk) disable iff (!rst_n)
        wr.push |-> accept && !item.start_name && expect_high_reg)
        else $error("unit pushed without a held low byte");

endmodule

FILE: rtl/u2u8_queue.sv
// Short register queue of classified code units between front and back.
// Depends on u2u8_pkg.
module u2u8_queue
    import u2u8_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  q_wr_t wr,
    input  logic  rd_take,
    output q_rd_t rd,
    output logic  q_full
);

    unit_entry_t         slot_reg [QDEPTH];
    logic [QPTR_W-1:0]   wptr_reg, wptr_next;
    logic [QPTR_W-1:0]   rptr_reg, rptr_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;
    logic                do_wr, do_rd;

    always_comb
    begin
        q_full   = (cnt_reg == QCNT_W'(QDEPTH));
        rd.avail = (cnt_reg != '0);
        rd.entry = slot_reg[rptr_reg];
        do_wr    = wr.push && !q_full;
        do_rd    = rd_take && rd.avail;
        wptr_next = do_wr ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next = do_rd ? rptr_reg + 1'b1 : rptr_reg;
        cnt_next  = cnt_reg + QCNT_W'(do_wr) - QCNT_W'(do_rd);
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            slot_reg[wptr_reg] <= wr.entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !wr.push)
        else $error("push into full unit queue");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QCNT_W'(QDEPTH))
        else $error("unit queue count out of range");

endmodule

FILE: rtl/u2u8_back.sv
// Back end: expands one queued code unit into its UTF-8 bytes, one per transaction.
// Depends on u2u8_pkg.
module u2u8_back
    import u2u8_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  q_rd_t     rd,
    output logic      rd_take,
    output out_item_t result,
    output logic      empty,
    input  logic      pop
);

    logic              valid_reg, valid_next;
    unit_entry_t       cur_reg, cur_next;
    logic [1:0]        idx_reg, idx_next;
    logic              is_last;
    logic              load;

    always_comb
    begin
        is_last = (idx_reg == last_idx(cur_reg.len));
        empty   = !valid_reg;
        result.out_byte     = enc_byte(cur_reg.unit, cur_reg.len, idx_reg);
        result.last_of_char = is_last;

        // reload when idle or as the final byte of the current unit goes out
        load    = !valid_reg || (pop && is_last);
        rd_take = load && rd.avail;

        valid_next = valid_reg;
        cur_next   = cur_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            valid_next = rd.avail;
            cur_next   = rd.entry;
            idx_next   = 2'd0;
        end
        else if (pop)
            idx_next = idx_reg + 1'b1;
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> idx_reg <= last_idx(cur_reg.len))
        else $error("byte index past end of character");

    a_new_unit_first: assert property (@(posedge clk) disable iff (!rst_n)
        rd_take |=> idx_reg == 2'd0 && valid_reg)
        else $error("new unit not started at its lead byte");

endmodule

FILE: rtl/ucs2_le_to_utf8_encoder.sv
// Top level of the UCS-2 little-endian to UTF-8 name encoder.
// Depends on u2u8_pkg, u2u8_front, u2u8_queue, u2u8_back.
//
//  channel   handshake         payload
//  input     push / full       item   (in_byte, start_name)
//  result    empty / pop       result (out_byte, last_of_char)
//  config    cfg_we            cfg_data (name_length)
//
// One byte is taken per cycle while full is low; each high byte that completes a nonzero
// unit within the name length yields one to three result bytes, and the back end emits
// one result byte per cycle while pop is high. The four-entry unit queue decouples the
// sides; full rises when it holds four units. Reset is asynchronous and clears
// all control state and name_length to 10. Results wait on the ports while pop is low.
module ucs2_le_to_utf8_encoder
    import u2u8_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  in_item_t             item,
    output logic                 empty,
    input  logic                 pop,
    output out_item_t            result,
    input  logic                 cfg_we,
    input  logic [LEN_CFG_W-1:0] cfg_data
);

    q_wr_t wr;
    q_rd_t rd;
    logic  rd_take;
    logic  q_full;
    logic  accept;

    assign full   = q_full;
    assign accept = push && !q_full;

    u2u8_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .item     (item),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .wr       (wr)
    );

    u2u8_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .rd_take (rd_take),
        .rd      (rd),
        .q_full  (q_full)
    );

    u2u8_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd      (rd),
        .rd_take (rd_take),
        .result  (result),
        .empty   (empty),
        .pop     (pop)
    );

endmodule
